[hdl/mse_pkg.sv]
// Shared types, constants and the marching-squares case table of the edge emitter.
// Used by mse_edge_gen, the top level and the port checker; no dependencies.

package mse_pkg;

  // field widths fixed by the interface
  localparam int unsigned SizeWidth  = 11;
  localparam int unsigned CoordWidth = 13;
  localparam int unsigned InDataWidth  = 8;
  localparam int unsigned OutDataWidth = 56;

  // configuration register indexes
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef logic [SizeWidth-1:0]  size_t;
  typedef logic [CoordWidth-1:0] coord_t;

  // one edge, start_x in the lowest bits
  typedef struct packed {
    coord_t end_y;
    coord_t end_x;
    coord_t start_y;
    coord_t start_x;
  } edge_t;

  localparam int unsigned EdgeWidth = $bits(edge_t);

  // case entry: edge count and eight offsets in {-1, 0, 1}
  // d[0..3] = start x, start y, end x, end y of the first edge, d[4..7] of the second
  typedef struct packed {
    logic [1:0]      count;
    logic [7:0][1:0] d;
  } case_t;

  // edges produced for one cell
  typedef struct packed {
    logic [1:0] count;
    edge_t      edge0;
    edge_t      edge1;
  } cell_edges_t;

  localparam logic [1:0] Dn = 2'b11;  // -1
  localparam logic [1:0] Dz = 2'b00;  //  0
  localparam logic [1:0] Dp = 2'b01;  // +1

  // case index = LL | LR<<1 | UR<<2 | UL<<3
  function automatic case_t case_lookup(input logic [3:0] idx);
    case_t e;
    e.count = 2'd1;
    e.d     = '0;
    unique case (idx)
      4'd0, 4'd15: e.count = 2'd0;
      4'd1, 4'd14: e.d[3:0] = {Dp, Dz, Dz, Dn};
      4'd2, 4'd13: e.d[3:0] = {Dz, Dp, Dp, Dz};
      4'd3, 4'd12: e.d[3:0] = {Dz, Dp, Dz, Dn};
      4'd4, 4'd11: e.d[3:0] = {Dn, Dz, Dz, Dp};
      4'd6, 4'd9:  e.d[3:0] = {Dn, Dz, Dp, Dz};
      4'd7, 4'd8:  e.d[3:0] = {Dz, Dn, Dn, Dz};
      // saddle cases fill both edge slots
      4'd5: begin
        e.count = 2'd2;
        e.d     = {Dz, Dp, Dp, Dz, Dz, Dn, Dn, Dz};
      end
      4'd10: begin
        e.count = 2'd2;
        e.d     = {Dn, Dz, Dz, Dp, Dp, Dz, Dz, Dn};
      end
      default: e.count = 2'd0;
    endcase
    return e;
  endfunction

endpackage

[hdl/mse_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module mse_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, hold while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/mse_edge_gen.sv]
// Case table lookup and offset of edge end points by the doubled cell position.
// Depends on mse_pkg.

module mse_edge_gen (
  input  logic [3:0]           case_idx,
  input  mse_pkg::coord_t      px,
  input  mse_pkg::coord_t      py,
  output mse_pkg::cell_edges_t edges
);

  mse_pkg::case_t entry;

  function automatic mse_pkg::coord_t add_off(input mse_pkg::coord_t base,
                                              input logic [1:0] off);
    mse_pkg::coord_t ext;
    ext = {{(mse_pkg::CoordWidth-2){off[1]}}, off};
    return base + ext;
  endfunction

  // look up the case and add offsets, two's complement wrap to 13 bits
  always_comb begin
    entry = mse_pkg::case_lookup(case_idx);
    edges.count         = entry.count;
    edges.edge0.start_x = add_off(px, entry.d[0]);
    edges.edge0.start_y = add_off(py, entry.d[1]);
    edges.edge0.end_x   = add_off(px, entry.d[2]);
    edges.edge0.end_y   = add_off(py, entry.d[3]);
    edges.edge1.start_x = add_off(px, entry.d[4]);
    edges.edge1.start_y = add_off(py, entry.d[5]);
    edges.edge1.end_x   = add_off(px, entry.d[6]);
    edges.edge1.end_y   = add_off(py, entry.d[7]);
  end

endmodule

[hdl/marching_squares_edge_emitter_unit.sv]
// An accepted pixel word goes through the input register, then the output register.
// Throughput: one pixel per cycle while the output is not stalled; a saddle cell holds the
// output register for both its edge words, so the rate is set by the single output register
// and its one-word pending slot.
// The previous row lives in a (MAX_WIDTH+2)-entry RAM with registered read, no clearing pass.
// Reset (rst, synchronous): clears counters, neighbor pixels, valids; sizes go to 1024,
// capped at the maximum. Depends on mse_pkg, mse_ram, mse_edge_gen.

module marching_squares_edge_emitter_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  mse_pkg::size_t                    cfg_data,
  // pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [mse_pkg::InDataWidth-1:0]   s_tdata,   // [0] pixel
  // edge stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mse_pkg::OutDataWidth-1:0]  m_tdata,   // start_x, start_y, end_x, end_y
  output logic                              m_tlast,   // last_edge
  output logic                              m_tuser    // frame_done
);

  localparam int unsigned StoreDepth = MAX_WIDTH + 2;
  localparam int unsigned AddrWidth  = $clog2(StoreDepth);
  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);
  localparam int unsigned ResetW = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned ResetH = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  // sizes and raster position
  mse_pkg::size_t image_width, image_height;
  mse_pkg::size_t column_count, row_count;
  logic           left_pixel, upper_left_pixel;

  // stage 1 registers
  logic                  s1_valid, s1_cell, s1_cur, s1_ll, s1_in_store, s1_frame;
  logic [AddrWidth-1:0]  s1_addr;
  mse_pkg::coord_t       s1_px, s1_py;

  // output register and pending saddle edge word
  logic                  o_valid, o_last, o_frame, pend_valid;
  mse_pkg::edge_t        o_word, pend_word;

  logic                  in_acc, s1_go, s1_retire, out_free, out_load;
  logic [11:0]           w_plus1, h_plus1;
  logic                  border, cur, row_end, frame_end, in_store;
  logic                  up, rd_up;
  mse_pkg::cell_edges_t  edges;

  // clamp a written size into 1..max
  function automatic mse_pkg::size_t clamp_size(input mse_pkg::size_t v,
                                                input logic [12:0] maxv);
    mse_pkg::size_t r;
    if (v == '0) begin
      r = mse_pkg::size_t'(1);
    end else if ({2'b00, v} > maxv) begin
      r = maxv[mse_pkg::SizeWidth-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mse_pkg::size_t'(ResetW);
      image_height <= mse_pkg::size_t'(ResetH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mse_pkg::CfgImageWidth:  image_width  <= clamp_size(cfg_data, MaxW);
        mse_pkg::CfgImageHeight: image_height <= clamp_size(cfg_data, MaxH);
        default: ;
      endcase
    end
  end

  // classify the incoming position
  always_comb begin
    w_plus1   = {1'b0, image_width} + 12'd1;
    h_plus1   = {1'b0, image_height} + 12'd1;
    row_end   = {1'b0, column_count} >= w_plus1;
    frame_end = row_end && ({1'b0, row_count} >= h_plus1);
    border    = (column_count == '0) || row_end ||
                (row_count == '0) || ({1'b0, row_count} >= h_plus1);
    cur       = border ? 1'b0 : s_tdata[0];
    in_store  = 32'(column_count) < 32'(StoreDepth);
  end

  // handshake between stages
  always_comb begin
    out_free  = !o_valid || (m_tready && !pend_valid);
    s1_go     = !s1_cell || (edges.count == 2'd0) || out_free;
    s1_retire = s1_valid && s1_go;
    s_tready  = !s1_valid || s1_go;
    in_acc    = s_tvalid && s_tready;
    out_load  = s1_retire && s1_cell && (edges.count != 2'd0);
  end

  // advance raster position and left neighbor on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      left_pixel   <= 1'b0;
    end else if (in_acc) begin
      left_pixel <= cur;
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + mse_pkg::size_t'(1);
      end else begin
        column_count <= column_count + mse_pkg::size_t'(1);
      end
    end
  end

  // previous row store
  mse_ram #(
    .WIDTH(1),
    .DEPTH(StoreDepth)
  ) u_row_ram (
    .clk  (clk),
    .we   (s1_retire && s1_in_store),
    .waddr(s1_addr),
    .wdata(s1_cur),
    .re   (in_acc),
    .raddr(AddrWidth'(column_count)),
    .rdata(rd_up)
  );

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cell     <= (column_count != '0) && (row_count != '0);
      s1_cur      <= cur;
      s1_ll       <= left_pixel;
      s1_in_store <= in_store;
      s1_frame    <= frame_end;
      s1_addr     <= AddrWidth'(column_count);
      s1_px       <= mse_pkg::coord_t'({column_count - mse_pkg::size_t'(1), 1'b0});
      s1_py       <= mse_pkg::coord_t'({row_count - mse_pkg::size_t'(1), 1'b0});
    end
  end

  assign up = s1_in_store ? rd_up : 1'b0;

  // upper-left neighbor follows the retiring word
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_pixel <= 1'b0;
    end else if (s1_retire) begin
      upper_left_pixel <= up;
    end
  end

  mse_edge_gen u_edge_gen (
    .case_idx({upper_left_pixel, up, s1_cur, s1_ll}),
    .px      (s1_px),
    .py      (s1_py),
    .edges   (edges)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_load) begin
      o_valid    <= 1'b1;
      pend_valid <= (edges.count == 2'd2);
    end else if (o_valid && m_tready) begin
      o_valid    <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  // output payload: load a cell, or move the pending saddle edge up
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_word    <= edges.edge0;
      o_last    <= (edges.count != 2'd2);
      o_frame   <= s1_frame;
      pend_word <= edges.edge1;
    end else if (o_valid && m_tready && pend_valid) begin
      o_word <= pend_word;
      o_last <= 1'b1;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {{(mse_pkg::OutDataWidth-mse_pkg::EdgeWidth){1'b0}}, o_word};
  assign m_tlast  = o_last;
  assign m_tuser  = o_frame;

endmodule

[hdl/mse_port_checker.sv]
// Port-level checks of the edge emitter and the bind that attaches them.
// Depends on mse_pkg and marching_squares_edge_emitter_unit.

module mse_port_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [mse_pkg::OutDataWidth-1:0] m_tdata,
  input logic                             m_tlast,
  input logic                             m_tuser
);

  // hold a stalled edge word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled edge word changed");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("edge word valid after reset");

  // second saddle edge follows at once with the same frame flag
  a_saddle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast && (m_tuser == $past(m_tuser)))
    else $error("second saddle edge missing or frame flag changed");

  // every end point sits on a cell side: exactly one odd doubled coordinate
  a_midpoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] ^ m_tdata[13]) && (m_tdata[26] ^ m_tdata[39]))
    else $error("edge end point not on a cell side");

endmodule

bind marching_squares_edge_emitter_unit mse_port_checker u_port_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);
